// ===== src/assert_macros.svh =====
// Shared assertion macros for the parser checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define VGMP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define VGMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/vgmp_pkg.sv =====
package vgmp_pkg;

  // Event kinds on the result channel.
  localparam logic [2:0] KIND_PSG   = 3'd0;
  localparam logic [2:0] KIND_FM    = 3'd1;
  localparam logic [2:0] KIND_ADPCM = 3'd2;
  localparam logic [2:0] KIND_WAIT  = 3'd3;
  localparam logic [2:0] KIND_ROM   = 3'd4;
  localparam logic [2:0] KIND_LOOP  = 3'd5;
  localparam logic [2:0] KIND_DONE  = 3'd6;

  // Operand index value that marks the body of a data block.
  localparam logic [2:0] BODY_MARK = 3'd7;

  // Opcodes with special handling.
  localparam logic [7:0] OP_PSG_WRITE  = 8'h50;
  localparam logic [7:0] OP_FM_WRITE   = 8'h54;
  localparam logic [7:0] OP_WAIT_N     = 8'h61;
  localparam logic [7:0] OP_WAIT_735   = 8'h62;
  localparam logic [7:0] OP_WAIT_882   = 8'h63;
  localparam logic [7:0] OP_END        = 8'h66;
  localparam logic [7:0] OP_DATA_BLOCK = 8'h67;
  localparam logic [7:0] OP_ADPCM      = 8'hB8;
  localparam logic [7:0] BLK_TYPE_ROM  = 8'h8B;

  localparam logic [31:0] SAMPLES_735 = 32'd735;
  localparam logic [31:0] SAMPLES_882 = 32'd882;

  // Bytes of a data block header after the opcode.
  localparam logic [30:0] BLK_HDR_LEN = 31'd6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PSG_EN     = 3'd0;
  localparam logic [2:0] CFG_FM_EN      = 3'd1;
  localparam logic [2:0] CFG_LOOP_MODE  = 3'd2;
  localparam logic [2:0] CFG_LOOP_OFS   = 3'd3;
  localparam logic [2:0] CFG_TOTAL_SMP  = 3'd4;
  localparam logic [2:0] CFG_LOOP_SMP   = 3'd5;

  typedef struct packed {
    logic        psg_en;
    logic        fm_en;
    logic        loop_mode;
    logic [31:0] loop_ofs;
    logic [31:0] total_smp;
    logic [31:0] loop_smp;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       opcode;
    logic [30:0]      remaining;
    logic [3:0][7:0]  opnd;
    logic [2:0]       opnd_idx;
    logic [7:0]       block_type;
    logic [31:0]      rom_size;
    logic [31:0]      rom_addr;
    logic [30:0]      blk_idx;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] event_address;
    logic [7:0]  event_data;
    logic [31:0] event_count;
  } event_t;

  // Total command length in bytes, opcode included. Unknown opcodes are one byte.
  function automatic logic [2:0] cmd_length(input logic [7:0] op);
    logic [2:0] len;
    len = 3'd1;
    case (op) inside
      8'h50, 8'h4F, [8'h30:8'h3F]:               len = 3'd2;
      8'h54, 8'h61, 8'hB8, 8'hA0,
      [8'h40:8'h4E], [8'h51:8'h5F], [8'hB0:8'hBF]: len = 3'd3;
      8'h64, [8'hC0:8'hC8], [8'hD0:8'hD6]:         len = 3'd4;
      [8'hE0:8'hE3]:                               len = 3'd5;
      default:                                     len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

// ===== src/vgmp_byte_if.sv =====
interface vgmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

// ===== src/vgmp_event_if.sv =====
interface vgmp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] event_address;
  logic [7:0]  event_data;
  logic [31:0] event_count;

  modport source (output valid, output event_kind, output event_address,
                  output event_data, output event_count, input ready);
  modport sink   (input valid, input event_kind, input event_address,
                  input event_data, input event_count, output ready);
endinterface

// ===== src/vgmp_step.sv =====
module vgmp_step
  import vgmp_pkg::*;
(
  input  cfg_t         cfg,
  input  parse_state_t st,
  input  logic [7:0]   stream_byte,
  output parse_state_t st_nxt,
  output logic         ev_valid,
  output event_t       ev
);

  logic [2:0]  len;
  logic [2:0]  hdr_sel;
  logic [30:0] blk_len;
  logic [31:0] rom_ofs;

  // Event of a command whose last byte has arrived.
  function automatic logic [$bits(event_t):0] execute(input logic [7:0] op,
                                                      input logic [3:0][7:0] opnd,
                                                      input cfg_t c);
    event_t e;
    logic   v;
    e = '0;
    v = 1'b0;
    case (op) inside
      OP_PSG_WRITE: begin
        v = c.psg_en;
        e.event_kind = KIND_PSG;
        e.event_data = opnd[0];
      end
      OP_FM_WRITE: begin
        v = c.fm_en;
        e.event_kind = KIND_FM;
        e.event_address = {24'd0, opnd[0]};
        e.event_data = opnd[1];
      end
      OP_WAIT_N: begin
        v = 1'b1;
        e.event_kind = KIND_WAIT;
        e.event_count = {16'd0, opnd[1], opnd[0]};
      end
      OP_WAIT_735: begin
        v = 1'b1;
        e.event_kind = KIND_WAIT;
        e.event_count = SAMPLES_735;
      end
      OP_WAIT_882: begin
        v = 1'b1;
        e.event_kind = KIND_WAIT;
        e.event_count = SAMPLES_882;
      end
      [8'h70:8'h7F]: begin
        v = 1'b1;
        e.event_kind = KIND_WAIT;
        e.event_count = {28'd0, op[3:0]} + 32'd1;
      end
      OP_ADPCM: begin
        v = 1'b1;
        e.event_kind = KIND_ADPCM;
        e.event_data = opnd[1];
      end
      OP_END: begin
        v = 1'b1;
        if (c.loop_ofs != '0 && c.loop_mode) begin
          e.event_kind = KIND_LOOP;
          e.event_address = c.loop_ofs;
          e.event_count = (c.loop_smp < c.total_smp) ? (c.total_smp - c.loop_smp) : '0;
        end else begin
          e.event_kind = KIND_DONE;
        end
      end
      default: v = 1'b0;
    endcase
    return {v, e};
  endfunction

  assign len     = cmd_length(stream_byte);
  assign hdr_sel = st.opnd_idx - 3'd2;
  assign rom_ofs = {1'b0, st.blk_idx} - 32'd8;

  always_comb begin
    st_nxt   = st;
    ev_valid = 1'b0;
    ev       = '0;
    blk_len  = '0;
    if (st.remaining == '0) begin
      // Opcode byte.
      st_nxt.opcode   = stream_byte;
      st_nxt.opnd_idx = '0;
      if (stream_byte == OP_DATA_BLOCK) begin
        st_nxt.remaining = BLK_HDR_LEN;
      end else if (len == 3'd1) begin
        {ev_valid, ev}   = execute(stream_byte, st.opnd, cfg);
        st_nxt.opcode    = '0;
        st_nxt.remaining = '0;
      end else begin
        st_nxt.remaining = {28'd0, len - 3'd1};
      end
    end else if (st.opcode == OP_DATA_BLOCK && st.opnd_idx == BODY_MARK) begin
      // Body of a data block; ROM blocks carry size and address in their first 8 bytes.
      if (st.block_type == BLK_TYPE_ROM) begin
        if (st.blk_idx < 31'd4) begin
          st_nxt.rom_size[{st.blk_idx[1:0], 3'b000} +: 8] =
            st.rom_size[{st.blk_idx[1:0], 3'b000} +: 8] | stream_byte;
        end else if (st.blk_idx < 31'd8) begin
          st_nxt.rom_addr[{st.blk_idx[1:0], 3'b000} +: 8] =
            st.rom_addr[{st.blk_idx[1:0], 3'b000} +: 8] | stream_byte;
        end else begin
          ev_valid         = 1'b1;
          ev.event_kind    = KIND_ROM;
          ev.event_address = st.rom_addr + rom_ofs;
          ev.event_data    = stream_byte;
          ev.event_count   = st.rom_size;
        end
      end
      st_nxt.blk_idx   = st.blk_idx + 31'd1;
      st_nxt.remaining = st.remaining - 31'd1;
      if (st.remaining == 31'd1) begin
        st_nxt.opcode   = '0;
        st_nxt.opnd_idx = '0;
      end
    end else if (st.opcode == OP_DATA_BLOCK) begin
      // Header: compatibility byte, type, then 32-bit length.
      if (st.opnd_idx == 3'd1) begin
        st_nxt.block_type = stream_byte;
      end else if (st.opnd_idx >= 3'd2 && st.opnd_idx < 3'd6) begin
        st_nxt.opnd[hdr_sel[1:0]] = stream_byte;
      end
      st_nxt.opnd_idx  = st.opnd_idx + 3'd1;
      st_nxt.remaining = st.remaining - 31'd1;
      if (st.remaining == 31'd1) begin
        blk_len          = {st_nxt.opnd[3][6:0], st_nxt.opnd[2], st_nxt.opnd[1],
                            st_nxt.opnd[0]};
        st_nxt.blk_idx   = '0;
        st_nxt.rom_size  = '0;
        st_nxt.rom_addr  = '0;
        if (blk_len == '0) begin
          st_nxt.opcode    = '0;
          st_nxt.remaining = '0;
          st_nxt.opnd_idx  = '0;
        end else begin
          st_nxt.remaining = blk_len;
          st_nxt.opnd_idx  = BODY_MARK;
        end
      end
    end else begin
      // Operand of an ordinary command.
      if (st.opnd_idx < 3'd4) begin
        st_nxt.opnd[st.opnd_idx[1:0]] = stream_byte;
      end
      if (st.opnd_idx < 3'd6) begin
        st_nxt.opnd_idx = st.opnd_idx + 3'd1;
      end
      st_nxt.remaining = st.remaining - 31'd1;
      if (st.remaining == 31'd1) begin
        {ev_valid, ev}  = execute(st.opcode, st_nxt.opnd, cfg);
        st_nxt.opcode   = '0;
        st_nxt.opnd_idx = '0;
      end
    end
  end

endmodule

// ===== src/vgm_command_stream_parser.sv =====
// An event appears on out_evt after the beat of the byte that completes its
// command, passing the input register, then the result register.
// Throughput: one stream byte per cycle while out_evt is ready; the parse state
// update in the single decode stage sets that rate.
// Reset (rst_n low, synchronous): parser expects an opcode, no event is held,
// configuration registers return to their defaults (loop_mode 1, all others 0).
module vgm_command_stream_parser
  import vgmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  vgmp_byte_if.sink          in_byte,
  vgmp_event_if.source       out_evt,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  cfg_t         cfg_r;
  parse_state_t st_r;
  parse_state_t st_nxt;
  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_go;
  logic         out_valid_r;
  event_t       out_evt_r;
  logic         ev_valid;
  event_t       ev;

  // The decode stage advances when the result register is empty or being drained.
  assign s1_go         = s1_valid_r && (!out_valid_r || out_evt.ready);
  assign in_byte.ready = !s1_valid_r || s1_go;

  vgmp_step u_step (
    .cfg         (cfg_r),
    .st          (st_r),
    .stream_byte (s1_byte_r),
    .st_nxt      (st_nxt),
    .ev_valid    (ev_valid),
    .ev          (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      cfg_r       <= '{loop_mode: 1'b1, default: '0};
    end else begin
      if (in_byte.ready) begin
        s1_valid_r <= in_byte.valid;
      end
      if (s1_go) begin
        st_r        <= st_nxt;
        out_valid_r <= ev_valid;
      end else if (out_evt.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PSG_EN:    cfg_r.psg_en    <= cfg_wdata[0];
          CFG_FM_EN:     cfg_r.fm_en     <= cfg_wdata[0];
          CFG_LOOP_MODE: cfg_r.loop_mode <= cfg_wdata[0];
          CFG_LOOP_OFS:  cfg_r.loop_ofs  <= cfg_wdata;
          CFG_TOTAL_SMP: cfg_r.total_smp <= cfg_wdata;
          CFG_LOOP_SMP:  cfg_r.loop_smp  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_byte.valid && in_byte.ready) begin
      s1_byte_r <= in_byte.stream_byte;
    end
    if (s1_go) begin
      out_evt_r <= ev;
    end
  end

  assign out_evt.valid         = out_valid_r;
  assign out_evt.event_kind    = out_evt_r.event_kind;
  assign out_evt.event_address = out_evt_r.event_address;
  assign out_evt.event_data    = out_evt_r.event_data;
  assign out_evt.event_count   = out_evt_r.event_count;

endmodule

// ===== src/vgmp_checker.sv =====
`include "assert_macros.svh"

module vgmp_checker
  import vgmp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_address,
  input logic [7:0]  out_data,
  input logic [31:0] out_count
);

  `VGMP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "event valid after reset")

  `VGMP_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_address) && $stable(out_data) && $stable(out_count), "stalled event changed")

  `VGMP_ASSERT(a_kind_known, clk, rst_n, out_valid |-> out_kind <= KIND_DONE, "unknown event kind")

  `VGMP_ASSERT(a_wait_clean, clk, rst_n, out_valid && out_kind == KIND_WAIT |-> out_address == '0 && out_data == '0, "wait event with address or data")

endmodule

bind vgm_command_stream_parser vgmp_checker u_vgmp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_evt.valid),
  .out_ready   (out_evt.ready),
  .out_kind    (out_evt.event_kind),
  .out_address (out_evt.event_address),
  .out_data    (out_evt.event_data),
  .out_count   (out_evt.event_count)
);
